[rtl/itrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrb_pkg: shared types and constants of the I2C target register bank
// Holds event codes, field widths, reset values and the control/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package itrb_pkg;

    // Default register count of the bank
    localparam int unsigned REG_COUNT_DEF = 32;

    // Number of bus-writable scratch registers
    localparam int unsigned SCRATCH_SPAN = 4;

    // Field widths
    localparam int unsigned OP_W      = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned IDX_W     = 5;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned PTR_OUT_W = 5;

    // Stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 32;

    // Reset value of the scratch window base
    localparam logic [IDX_W-1:0] SCRATCH_BASE_RST = 5'd28;

    // Event codes
    localparam logic [OP_W-1:0] OP_BUS_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_BUS_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP     = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD     = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } itrb_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } itrb_status_t;

endpackage

[rtl/itrb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrb_ctrl: sequencing controller of the register bank
// Takes one event, waits for the registered bank read at the pointer, then
// commits the event once the result register is free.
// ----------------------------------------------------------------------------
module itrb_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  itrb_pkg::itrb_status_t status,
    output itrb_pkg::itrb_cmd_t    cmd
);
    import itrb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Accept only when no event is in flight
    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.commit  = (state_reg == ST_EXEC) && status.out_free;

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/itrb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrb_datapath: register store, pointer, counter and result register
// Holds the byte store with per-entry valid bits, the auto-incrementing
// pointer, the capture flag, the transaction counter and the output stage.
// ----------------------------------------------------------------------------
module itrb_datapath
#(
    parameter int unsigned REG_COUNT = itrb_pkg::REG_COUNT_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [itrb_pkg::IDX_W-1:0]           cfg_wdata,
    input  logic [itrb_pkg::OP_W-1:0]            in_op,
    input  logic [itrb_pkg::BYTE_W-1:0]          in_data_byte,
    input  logic [itrb_pkg::IDX_W-1:0]           in_load_index,
    input  itrb_pkg::itrb_cmd_t                  cmd,
    output itrb_pkg::itrb_status_t               status,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [itrb_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [0:0]                           m_tuser
);
    import itrb_pkg::*;

    localparam int unsigned PTR_W     = $clog2(REG_COUNT);
    localparam int unsigned PTR_EXT_W = (PTR_W > PTR_OUT_W) ? PTR_W : PTR_OUT_W;
    localparam int unsigned CMP_W     = (PTR_W + 1 > IDX_W + 1) ? PTR_W + 1 : IDX_W + 1;
    localparam int unsigned LUT_DEPTH = 2 ** BYTE_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(REG_COUNT - 1);

    // Byte store and its valid bits
    logic [BYTE_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0] bank_vld_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic rd_vld_reg;

    // Captured event
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [IDX_W-1:0]  load_idx_reg;

    // Architectural state
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic               armed_reg;
    logic               armed_next;
    logic [COUNT_W-1:0] xact_reg;
    logic [COUNT_W-1:0] xact_next;
    logic [IDX_W-1:0]   base_reg;

    // Output stage
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_rd_reg;
    logic               out_rv_reg;
    logic [COUNT_W-1:0] out_xact_reg;
    logic [PTR_OUT_W-1:0] out_ptr_reg;

    // Commit-time values
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [BYTE_W-1:0]  rd_byte;
    logic               rd_flag;
    logic [PTR_W-1:0]   ptr_inc;
    logic               in_window;
    logic               load_ok;
    logic [CMP_W-1:0]   ptr_cmp;
    logic [CMP_W-1:0]   base_cmp;
    logic [PTR_EXT_W-1:0] ptr_ext;

    // Pointer capture table: byte modulo register count
    logic [PTR_W-1:0] ptr_lut [LUT_DEPTH];

    for (genvar g = 0; g < LUT_DEPTH; g++)
    begin : g_lut
        localparam int unsigned MOD_VAL = g % REG_COUNT;
        assign ptr_lut[g] = PTR_W'(MOD_VAL);
    end

    // Pointer wrap and window tests
    assign ptr_inc   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
    assign ptr_cmp   = CMP_W'(ptr_reg);
    assign base_cmp  = CMP_W'(base_reg);
    assign in_window = (ptr_cmp >= base_cmp) && (ptr_cmp < base_cmp + CMP_W'(SCRATCH_SPAN));
    assign load_ok   = CMP_W'(load_idx_reg) < CMP_W'(REG_COUNT);
    assign ptr_ext   = PTR_EXT_W'(ptr_next);

    assign status.out_free = !out_valid_reg || m_tready;

    // Decode the event
    always_comb
    begin
        ptr_next   = ptr_reg;
        armed_next = armed_reg;
        xact_next  = xact_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        rd_byte    = '0;
        rd_flag    = 1'b0;
        unique case (op_reg)
            OP_BUS_BYTE:
            begin
                if (armed_reg)
                begin
                    ptr_next   = ptr_lut[data_reg];
                    armed_next = 1'b0;
                end
                else
                begin
                    wr_en    = in_window;
                    ptr_next = ptr_inc;
                end
            end
            OP_BUS_READ:
            begin
                rd_byte  = rd_vld_reg ? rd_data_reg : '0;
                rd_flag  = 1'b1;
                ptr_next = ptr_inc;
            end
            OP_STOP:
            begin
                armed_next = 1'b1;
                xact_next  = xact_reg + COUNT_W'(1);
            end
            OP_LOAD:
            begin
                wr_en   = load_ok;
                wr_addr = PTR_W'(load_idx_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Hold the event while it executes
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= in_op;
            data_reg     <= in_data_byte;
            load_idx_reg <= in_load_index;
        end
    end

    // Write the store on commit, read at the pointer every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            mem[wr_addr] <= data_reg;
        end
        rd_data_reg <= mem[ptr_reg];
        rd_vld_reg  <= bank_vld_reg[ptr_reg];
    end

    // Mark written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_vld_reg <= '0;
        end
        else if (cmd.commit && wr_en)
        begin
            bank_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Update pointer, capture flag, counter and window base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            armed_reg <= 1'b1;
            xact_reg  <= '0;
            base_reg  <= SCRATCH_BASE_RST;
        end
        else
        begin
            if (cmd.commit)
            begin
                ptr_reg   <= ptr_next;
                armed_reg <= armed_next;
                xact_reg  <= xact_next;
            end
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    // Result valid: set on commit, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_rd_reg   <= rd_byte;
            out_rv_reg   <= rd_flag;
            out_xact_reg <= xact_next;
            out_ptr_reg  <= ptr_ext[PTR_OUT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_ptr_reg, out_xact_reg, out_rd_reg});
    assign m_tuser  = out_rv_reg;

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(ptr_reg) < CMP_W'(REG_COUNT))
        else $error("pointer outside register bank");

    a_stop_arms: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (op_reg == OP_STOP) |=> armed_reg)
        else $error("stop did not arm pointer capture");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && (op_reg == OP_STOP)) |=> $stable(xact_reg))
        else $error("transaction count moved without a stop");

    a_load_keeps_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (op_reg == OP_LOAD) |=> $stable(ptr_reg) && $stable(armed_reg))
        else $error("local load changed pointer state");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_valid_reg || m_tready)
        else $error("commit over an untaken result");
`endif

endmodule

[rtl/i2c_target_register_bank_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_target_register_bank_top: byte register bank of an I2C target
// Each stream transfer is one bus event or one local load; each event
// returns one result transfer.
// ----------------------------------------------------------------------------
// Events are taken one at a time: an event is accepted, the bank is read at
// the current pointer through the registered read of the register store, and
// the event commits once the result register is free; a new event is taken
// only after the last has committed, from the idle state. A result waits in an
// output register; the next event is accepted while it waits, and its commit
// stalls only if the previous result has still not been taken. After reset
// the whole store reads as zero at once through per-entry valid bits, with no
// clearing pass. The scratch window base may be rewritten through cfg_we and
// cfg_wdata while no event is in flight.
// ----------------------------------------------------------------------------
module i2c_target_register_bank_top
#(
    parameter int unsigned REG_COUNT = itrb_pkg::REG_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Scratch window base register
    input  logic                           cfg_we,
    input  logic [itrb_pkg::IDX_W-1:0]     cfg_wdata,
    // Event input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] data_byte, [12:8] load_index, [15:13] zero
    input  logic [itrb_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] op
    input  logic [itrb_pkg::OP_W-1:0]      s_tuser,
    // Result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] read_data, [23:8] xact_count, [28:24] pointer, [31:29] zero
    output logic [itrb_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] read_valid
    output logic [0:0]                     m_tuser
);
    import itrb_pkg::*;

    itrb_cmd_t    cmd;
    itrb_status_t status;

    // Sequence events
    itrb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, pointer and result stage
    itrb_datapath
    #(
        .REG_COUNT (REG_COUNT)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_op         (s_tuser),
        .in_data_byte  (s_tdata[BYTE_W-1:0]),
        .in_load_index (s_tdata[BYTE_W+IDX_W-1:BYTE_W]),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the I2C target register bank
// Drives bus bytes, read requests, stop/restart events and local loads over
// the event stream. It mirrors the bank, pointer, capture flag and
// transaction counter in a local predictor, and compares every result
// transfer against the oldest prediction. A short table of directed events
// runs first. Randomized transactions follow under several window bases and
// backpressure mixes.
// ----------------------------------------------------------------------------
module testbench;
    import itrb_pkg::*;

    localparam int unsigned NUM_REGS    = REG_COUNT_DEF;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned PHASE_ITEMS = 90;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned NUM_ROWS    = 22;
    localparam int unsigned MAX_REPORTS = 40;

    typedef logic [OP_W-1:0] op_code_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    read_data;
        logic                 read_valid;
        logic [COUNT_W-1:0]   xact_count;
        logic [PTR_OUT_W-1:0] pointer;
    } bank_result_t;

    typedef struct packed {
        op_code_t          op;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  load_index;
        logic              fixed_exp;
        bank_result_t      want;
    } event_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    // Predictor state
    logic [BYTE_W-1:0] bank_mem [NUM_REGS];
    int unsigned       bank_ptr;
    logic              ptr_armed;
    logic [COUNT_W-1:0] xact_total;
    int unsigned       window_base;

    bank_result_t pending_results [$];
    event_row_t   dir_rows [NUM_ROWS];
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  error_count;
    int unsigned  items_sent;
    int unsigned  cycle_count;

    i2c_target_register_bank_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Apply one event to the mirrored bank and return its result
    function automatic bank_result_t bank_apply_event(op_code_t op,
                                                      logic [BYTE_W-1:0] data_byte,
                                                      logic [IDX_W-1:0] load_index);
        bank_result_t res;
        res = '0;
        case (op)
            OP_BUS_BYTE:
            begin
                if (ptr_armed)
                begin
                    bank_ptr  = int'(data_byte) % NUM_REGS;
                    ptr_armed = 1'b0;
                end
                else
                begin
                    if (bank_ptr >= window_base && bank_ptr < window_base + SCRATCH_SPAN)
                        bank_mem[bank_ptr] = data_byte;
                    bank_ptr = (bank_ptr + 1) % NUM_REGS;
                end
            end
            OP_BUS_READ:
            begin
                res.read_data  = bank_mem[bank_ptr];
                res.read_valid = 1'b1;
                bank_ptr       = (bank_ptr + 1) % NUM_REGS;
            end
            OP_STOP:
            begin
                ptr_armed  = 1'b1;
                xact_total = xact_total + COUNT_W'(1);
            end
            default:
            begin
                if (int'(load_index) < NUM_REGS)
                    bank_mem[load_index] = data_byte;
            end
        endcase
        res.xact_count = xact_total;
        res.pointer    = bank_ptr[PTR_OUT_W-1:0];
        return res;
    endfunction

    // Offer one event, wait for its transfer, and queue what it should return
    task automatic send_event(op_code_t op, logic [BYTE_W-1:0] data_byte,
                              logic [IDX_W-1:0] load_index,
                              logic fixed_exp = 1'b0, bank_result_t want = '0);
        bank_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-IDX_W-BYTE_W){1'b0}}, load_index, data_byte};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = bank_apply_event(op, data_byte, load_index);
        pending_results.push_back(fixed_exp ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // Rewrite the scratch window base once the bank has gone quiet
    task automatic set_window_base(logic [IDX_W-1:0] base);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(negedge clk);
        cfg_we      <= 1'b0;
        window_base = base;
    endtask

    // Pick a pointer byte, often landing around the scratch window
    function automatic logic [BYTE_W-1:0] pick_pointer_byte();
        int unsigned near;
        if ($urandom_range(0, 1) == 0)
            return BYTE_W'($urandom_range(0, 255));
        near = (window_base + $urandom_range(0, 5) + NUM_REGS - 1) % NUM_REGS;
        return BYTE_W'(near + NUM_REGS * $urandom_range(0, 7));
    endfunction

    // Run mostly well-formed transactions with some loads and noise
    task automatic run_random_phase(int unsigned target);
        int unsigned start;
        int unsigned kind;
        int unsigned n;
        start = items_sent;
        while (items_sent - start < target)
        begin
            kind = $urandom_range(0, 9);
            n    = $urandom_range(1, 6);
            if (kind <= 3)
            begin
                send_event(OP_STOP, BYTE_W'($urandom), IDX_W'($urandom));
                send_event(OP_BUS_BYTE, pick_pointer_byte(), IDX_W'($urandom));
                repeat (n) send_event(OP_BUS_BYTE, BYTE_W'($urandom), IDX_W'($urandom));
            end
            else if (kind <= 6)
            begin
                send_event(OP_STOP, BYTE_W'($urandom), IDX_W'($urandom));
                send_event(OP_BUS_BYTE, pick_pointer_byte(), IDX_W'($urandom));
                repeat (n) send_event(OP_BUS_READ, BYTE_W'($urandom), IDX_W'($urandom));
            end
            else if (kind == 7)
            begin
                repeat ((n + 1) / 2)
                    send_event(OP_LOAD, BYTE_W'($urandom), IDX_W'($urandom));
            end
            else if (kind == 8)
            begin
                // Keep reading from wherever the pointer stands
                repeat (n) send_event(OP_BUS_READ, BYTE_W'($urandom), IDX_W'($urandom));
            end
            else
            begin
                repeat ((n + 1) / 2)
                    send_event(op_code_t'($urandom), BYTE_W'($urandom), IDX_W'($urandom));
            end
        end
    endtask

    // Toggle result backpressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        bank_result_t got;
        bank_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[BYTE_W-1:0], m_tuser[0],
                   m_tdata[BYTE_W+COUNT_W-1:BYTE_W],
                   m_tdata[BYTE_W+COUNT_W+PTR_OUT_W-1:BYTE_W+COUNT_W]};
            if (pending_results.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: result with none expected: actual rd=%h rv=%b cnt=%0d ptr=%0d",
                             $time, got.read_data, got.read_valid, got.xact_count, got.pointer);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    if (error_count < MAX_REPORTS)
                        $display({"%0t: mismatch: expected rd=%h rv=%b cnt=%0d ptr=%0d,",
                                  " actual rd=%h rv=%b cnt=%0d ptr=%0d"},
                                 $time, want.read_data, want.read_valid, want.xact_count,
                                 want.pointer, got.read_data, got.read_valid,
                                 got.xact_count, got.pointer);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        logic [IDX_W-1:0] phase_bases [NUM_PHASES];

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_BUS_BYTE;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        items_sent     = 0;
        cycle_count    = 0;

        // Mirror the reset state
        foreach (bank_mem[i])
            bank_mem[i] = '0;
        bank_ptr    = 0;
        ptr_armed   = 1'b1;
        xact_total  = '0;
        window_base = SCRATCH_BASE_RST;

        // Directed events, starting from reset with the window at 28..31
        dir_rows = '{
            '{OP_BUS_READ, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b1, 16'd0, 5'd1}},
            '{OP_STOP,     8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, 16'd1, 5'd1}},
            '{OP_BUS_BYTE, 8'hFF, 5'd0,  1'b1, '{8'h00, 1'b0, 16'd1, 5'd31}},
            '{OP_BUS_BYTE, 8'hAA, 5'd0,  1'b1, '{8'h00, 1'b0, 16'd1, 5'd0}},
            '{OP_BUS_BYTE, 8'h55, 5'd0,  1'b1, '{8'h00, 1'b0, 16'd1, 5'd1}},
            '{OP_BUS_READ, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b1, 16'd1, 5'd2}},
            '{OP_LOAD,     8'h00, 5'd31, 1'b0, '0},
            '{OP_LOAD,     8'hFF, 5'd0,  1'b0, '0},
            '{OP_LOAD,     8'h6C, 5'd21, 1'b0, '0},
            '{OP_STOP,     8'h00, 5'd0,  1'b0, '0},
            '{OP_BUS_BYTE, 8'h1C, 5'd0,  1'b0, '0},
            '{OP_BUS_BYTE, 8'h00, 5'd0,  1'b0, '0},
            '{OP_BUS_BYTE, 8'hFF, 5'd0,  1'b0, '0},
            '{OP_BUS_BYTE, 8'h5A, 5'd0,  1'b0, '0},
            '{OP_BUS_BYTE, 8'hA5, 5'd0,  1'b0, '0},
            '{OP_STOP,     8'h00, 5'd0,  1'b0, '0},
            '{OP_BUS_BYTE, 8'h3C, 5'd0,  1'b0, '0},
            '{OP_BUS_READ, 8'h00, 5'd0,  1'b0, '0},
            '{OP_BUS_READ, 8'h00, 5'd0,  1'b0, '0},
            '{OP_BUS_READ, 8'h00, 5'd0,  1'b0, '0},
            '{OP_BUS_READ, 8'h00, 5'd0,  1'b0, '0},
            '{OP_BUS_READ, 8'h00, 5'd0,  1'b0, '0}
        };

        phase_bases = '{5'd0, 5'd3, 5'd28, 5'd17,
                        IDX_W'($urandom_range(0, 28)), 5'd26, 5'd9, 5'd28};

        // Hold reset, then release it at a falling clock edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_event(dir_rows[i].op, dir_rows[i].data_byte, dir_rows[i].load_index,
                       dir_rows[i].fixed_exp, dir_rows[i].want);

        // Randomized phases, rotating the backpressure mix
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_window_base(phase_bases[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            run_random_phase(PHASE_ITEMS);
        end

        // Drain and let the pipeline settle
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
